/* rtl/fsg_pkg.sv */
`default_nettype none

package fsg_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int GW_W       = 7;
    localparam int GH_W       = 6;
    localparam int SEED_W     = 16;
    localparam int COORD_W    = 6;
    localparam int CELL_W     = 2;
    localparam int OP_W       = 2;

    typedef logic [CELL_W-1:0] cell_t;

    localparam cell_t CELL_EMPTY = 2'd0;
    localparam cell_t CELL_SAND  = 2'd1;
    localparam cell_t CELL_WALL  = 2'd2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RNG_SEED    = 2'd2;

    localparam logic [GW_W-1:0]   GW_RESET   = 7'd64;
    localparam logic [GH_W-1:0]   GH_RESET   = 6'd63;
    localparam logic [SEED_W-1:0] SEED_RESET = 16'd1;
    localparam logic [SEED_W-1:0] LFSR_MASK  = 16'hB400;

    localparam int DIM_MIN    = 5;
    localparam int GW_CAP     = 64;
    localparam int GH_CAP     = 63;
    localparam int SCAN_START = 2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_SWEEP_TAIL,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PROBE_A,
        ST_PROBE_B,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        RD_HOST,
        RD_COUNT,
        RD_SELF,
        RD_DOWN,
        RD_DIAG_A,
        RD_DIAG_B
    } rd_sel_t;

    typedef struct packed {
        logic    clear_wr;
        logic    host_wr;
        logic    sweep;
        logic    scan_init;
        logic    lfsr_step;
        logic    save_free_c;
        logic    save_free_a;
        logic    place_sand;
        logic    scan_adv;
        logic    capture_op;
        logic    load_out;
        logic    out_port;
        logic    out_mem;
        rd_sel_t rd_sel;
    } fsg_cmd_t;

    typedef struct packed {
        logic cnt_last;
        logic cell_sand;
        logic scan_last;
        logic out_full;
    } fsg_status_t;

endpackage

`default_nettype wire

/* rtl/falling_sand_grid_step_core.sv */
`default_nettype none

// Falling-sand grid engine. Write and the unused operation code load the output
// register when accepted, a read from the read state that follows; the result sits
// there until taken, and a new word is accepted while idle once that register is
// free or draining. A step runs a copy pass over the whole cell memory, then scans
// the inner cells: each is read and checked, and a sand cell also probes the cell
// below and both diagonals before its move is decided; a final state posts the
// result. After reset a clearing pass over the whole memory empties the grid before
// the first word is accepted; configuration writes are taken throughout.
module falling_sand_grid_step_core #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [fsg_pkg::OP_W-1:0]          operation,
    input  logic [fsg_pkg::COORD_W-1:0]       x_coord,
    input  logic [fsg_pkg::COORD_W-1:0]       y_coord,
    input  logic [fsg_pkg::CELL_W-1:0]        cell_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fsg_pkg::CELL_W-1:0]        cell_out,
    output logic [fsg_pkg::OP_W-1:0]          op_done
);
    import fsg_pkg::*;

    fsg_cmd_t    cmd;
    fsg_status_t status;

    fsg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .out_stall (out_stall),
        .in_stall  (in_stall),
        .status    (status),
        .cmd       (cmd)
    );

    fsg_datapath #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operation (operation),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .cell_in   (cell_in),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_out  (cell_out),
        .op_done   (op_done)
    );

endmodule

`default_nettype wire

/* rtl/fsg_ctrl.sv */
`default_nettype none

module fsg_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [fsg_pkg::OP_W-1:0]  operation,
    input  logic                      out_stall,
    output logic                      in_stall,
    input  fsg_pkg::fsg_status_t      status,
    output fsg_pkg::fsg_cmd_t         cmd
);
    import fsg_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_free;
    logic   accept;
    op_t    op;

    assign op       = op_t'(operation);
    assign out_free = !status.out_full || !out_stall;
    assign in_stall = !((state_reg == ST_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (op) inside
                        OP_READ:         state_next = ST_READ;
                        OP_STEP:         state_next = ST_SWEEP;
                        OP_WRITE, OP_NOP: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ:       state_next = ST_IDLE;
            ST_SWEEP:
            begin
                if (status.cnt_last)
                begin
                    state_next = ST_SWEEP_TAIL;
                end
            end
            ST_SWEEP_TAIL: state_next = ST_SCAN_RD;
            ST_SCAN_RD:    state_next = ST_SCAN_CHK;
            ST_SCAN_CHK:
            begin
                if (status.cell_sand)
                begin
                    state_next = ST_PROBE_A;
                end
                else if (status.scan_last)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_PROBE_A:    state_next = ST_PROBE_B;
            ST_PROBE_B:    state_next = ST_DECIDE;
            ST_DECIDE:
            begin
                state_next = status.scan_last ? ST_FINISH : ST_SCAN_RD;
            end
            ST_FINISH:     state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.rd_sel = RD_HOST;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
            end
            ST_IDLE:
            begin
                cmd.capture_op = accept;
                if (accept)
                begin
                    unique case (op) inside
                        OP_WRITE:
                        begin
                            cmd.host_wr  = 1'b1;
                            cmd.load_out = 1'b1;
                            cmd.out_port = 1'b1;
                        end
                        OP_NOP:
                        begin
                            cmd.load_out = 1'b1;
                            cmd.out_port = 1'b1;
                        end
                        OP_READ, OP_STEP:
                        begin
                            cmd.load_out = 1'b0;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.load_out = 1'b1;
                cmd.out_mem  = 1'b1;
            end
            ST_SWEEP:
            begin
                cmd.sweep  = 1'b1;
                cmd.rd_sel = RD_COUNT;
            end
            ST_SWEEP_TAIL:
            begin
                cmd.scan_init = 1'b1;
            end
            ST_SCAN_RD:
            begin
                cmd.rd_sel = RD_SELF;
            end
            ST_SCAN_CHK:
            begin
                if (status.cell_sand)
                begin
                    cmd.lfsr_step = 1'b1;
                    cmd.rd_sel    = RD_DOWN;
                end
                else
                begin
                    cmd.scan_adv = 1'b1;
                end
            end
            ST_PROBE_A:
            begin
                cmd.save_free_c = 1'b1;
                cmd.rd_sel      = RD_DIAG_A;
            end
            ST_PROBE_B:
            begin
                cmd.save_free_a = 1'b1;
                cmd.rd_sel      = RD_DIAG_B;
            end
            ST_DECIDE:
            begin
                cmd.place_sand = 1'b1;
                cmd.scan_adv   = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.load_out = 1'b1;
            end
            default:
            begin
                cmd.rd_sel = RD_HOST;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/fsg_datapath.sv */
`default_nettype none

module fsg_datapath #(
    parameter int MAX_COLS = 64,
    parameter int MAX_ROWS = 64
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [fsg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fsg_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [fsg_pkg::OP_W-1:0]          operation,
    input  logic [fsg_pkg::COORD_W-1:0]       x_coord,
    input  logic [fsg_pkg::COORD_W-1:0]       y_coord,
    input  logic [fsg_pkg::CELL_W-1:0]        cell_in,
    input  fsg_pkg::fsg_cmd_t                 cmd,
    output fsg_pkg::fsg_status_t              status,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fsg_pkg::CELL_W-1:0]        cell_out,
    output logic [fsg_pkg::OP_W-1:0]          op_done
);
    import fsg_pkg::*;

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int DEPTH = 2 ** AW;
    localparam int WW    = $clog2(MAX_COLS + 1);
    localparam int W_HI  = (MAX_COLS < GW_CAP) ? MAX_COLS : GW_CAP;
    localparam int H_HI  = (MAX_ROWS - 1 < GH_CAP) ? MAX_ROWS - 1 : GH_CAP;

    cell_t grid_mem [DEPTH];
    cell_t snap_mem [DEPTH];

    logic [GW_W-1:0]   gw_reg;
    logic [GH_W-1:0]   gh_reg;
    logic [SEED_W-1:0] lfsr_reg;
    logic [SEED_W-1:0] lfsr_next;
    logic [AW-1:0]     cnt_reg;
    logic              pend_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic [CW-1:0]     x_reg;
    logic [RW-1:0]     y_reg;
    logic              dir_reg;
    logic              free_c_reg;
    logic              free_a_reg;
    logic [OP_W-1:0]   op_reg;
    logic              out_valid_reg;
    cell_t             cell_out_reg;
    logic [OP_W-1:0]   op_done_reg;
    cell_t             grid_q_reg;
    cell_t             snap_q_reg;

    logic [WW-1:0]     w_eff;
    logic [RW-1:0]     h_eff;
    logic              host_in_grid;
    logic [AW-1:0]     host_addr;
    logic [CW-1:0]     sw_x;
    logic [RW-1:0]     sw_y;
    logic              sw_border;
    logic [CW-1:0]     xa;
    logic [CW-1:0]     xb;
    logic [RW-1:0]     y_dn;
    logic [AW-1:0]     rd_addr;
    logic              free_b;
    logic              grid_we;
    logic [AW-1:0]     grid_waddr;
    cell_t             grid_wdata;
    logic              row_last;

    always_comb
    begin
        if (int'(gw_reg) < DIM_MIN)
        begin
            w_eff = WW'(DIM_MIN);
        end
        else if (int'(gw_reg) > W_HI)
        begin
            w_eff = WW'(W_HI);
        end
        else
        begin
            w_eff = WW'(gw_reg);
        end
        if (int'(gh_reg) < DIM_MIN)
        begin
            h_eff = RW'(DIM_MIN);
        end
        else if (int'(gh_reg) > H_HI)
        begin
            h_eff = RW'(H_HI);
        end
        else
        begin
            h_eff = RW'(gh_reg);
        end
    end

    assign host_in_grid = (int'(x_coord) < int'(w_eff)) && (int'(y_coord) <= int'(h_eff));
    assign host_addr    = host_in_grid ? {RW'(y_coord), CW'(x_coord)} : '0;

    assign sw_x      = cnt_reg[CW-1:0];
    assign sw_y      = cnt_reg[AW-1:CW];
    assign sw_border = (int'(sw_x) < int'(w_eff)) && (sw_y <= h_eff)
                       && (sw_x == '0 || sw_x == CW'(1) || int'(sw_x) == int'(w_eff) - 1
                           || sw_y == '0 || sw_y == RW'(1)
                           || sw_y == h_eff - RW'(1) || sw_y == h_eff);

    assign xa   = dir_reg ? x_reg - CW'(1) : x_reg + CW'(1);
    assign xb   = dir_reg ? x_reg + CW'(1) : x_reg - CW'(1);
    assign y_dn = y_reg + RW'(1);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_HOST:   rd_addr = host_addr;
            RD_COUNT:  rd_addr = cnt_reg;
            RD_SELF:   rd_addr = {y_reg, x_reg};
            RD_DOWN:   rd_addr = {y_dn, x_reg};
            RD_DIAG_A: rd_addr = {y_dn, xa};
            RD_DIAG_B: rd_addr = {y_dn, xb};
            default:   rd_addr = host_addr;
        endcase
    end

    assign free_b = (snap_q_reg == CELL_EMPTY) && (grid_q_reg == CELL_EMPTY);

    always_comb
    begin
        grid_we    = 1'b0;
        grid_waddr = cnt_reg;
        grid_wdata = CELL_EMPTY;
        if (cmd.clear_wr)
        begin
            grid_we = 1'b1;
        end
        else if (cmd.sweep)
        begin
            grid_we    = 1'b1;
            grid_wdata = sw_border ? CELL_WALL : CELL_EMPTY;
        end
        else if (cmd.host_wr && host_in_grid)
        begin
            grid_we    = 1'b1;
            grid_waddr = host_addr;
            grid_wdata = cell_in;
        end
        else if (cmd.place_sand)
        begin
            grid_we    = 1'b1;
            grid_wdata = CELL_SAND;
            if (free_c_reg)
            begin
                grid_waddr = {y_dn, x_reg};
            end
            else if (free_a_reg)
            begin
                grid_waddr = {y_dn, xa};
            end
            else if (free_b)
            begin
                grid_waddr = {y_dn, xb};
            end
            else
            begin
                grid_waddr = {y_reg, x_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (grid_we)
        begin
            grid_mem[grid_waddr] <= grid_wdata;
        end
        grid_q_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            snap_mem[pend_addr_reg] <= grid_q_reg;
        end
        snap_q_reg <= snap_mem[rd_addr];
    end

    assign lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_MASK : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg        <= GW_RESET;
            gh_reg        <= GH_RESET;
            lfsr_reg      <= SEED_RESET;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_GRID_WIDTH:  gw_reg <= cfg_data[GW_W-1:0];
                    CFG_GRID_HEIGHT: gh_reg <= cfg_data[GH_W-1:0];
                    CFG_RNG_SEED:    lfsr_reg <= (cfg_data == '0) ? SEED_RESET : cfg_data;
                    default:         gw_reg <= gw_reg;
                endcase
            end
            if (cmd.lfsr_step)
            begin
                lfsr_reg <= lfsr_next;
            end
            if (cmd.clear_wr || cmd.sweep)
            begin
                cnt_reg <= cnt_reg + AW'(1);
            end
            pend_reg <= cmd.sweep;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign row_last = (WW'(x_reg) + WW'(SCAN_START)) == w_eff;

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= cnt_reg;
        if (cmd.scan_init)
        begin
            x_reg <= CW'(SCAN_START);
            y_reg <= h_eff - RW'(SCAN_START);
        end
        else if (cmd.scan_adv)
        begin
            if (row_last)
            begin
                x_reg <= CW'(SCAN_START);
                y_reg <= y_reg - RW'(1);
            end
            else
            begin
                x_reg <= x_reg + CW'(1);
            end
        end
        if (cmd.lfsr_step)
        begin
            dir_reg <= lfsr_next[0];
        end
        if (cmd.save_free_c)
        begin
            free_c_reg <= free_b;
        end
        if (cmd.save_free_a)
        begin
            free_a_reg <= free_b;
        end
        if (cmd.capture_op)
        begin
            op_reg <= operation;
        end
        if (cmd.load_out)
        begin
            cell_out_reg <= cmd.out_mem ? grid_q_reg : CELL_EMPTY;
            op_done_reg  <= cmd.out_port ? operation : op_reg;
        end
    end

    assign status.cnt_last  = &cnt_reg;
    assign status.cell_sand = (snap_q_reg == CELL_SAND);
    assign status.scan_last = row_last && (y_reg == RW'(SCAN_START));
    assign status.out_full  = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign op_done   = op_done_reg;

endmodule

`default_nettype wire

/* rtl/fsg_checker.sv */
`default_nettype none

module fsg_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic [fsg_pkg::OP_W-1:0]          operation,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic [fsg_pkg::CELL_W-1:0]        cell_out,
    input  logic [fsg_pkg::OP_W-1:0]          op_done
);
    import fsg_pkg::*;

    logic in_acc;

    assign in_acc = in_valid && !in_stall;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cell_out) && $stable(op_done))
        else $error("stalled result word changed");

    a_zero_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (op_done != OP_READ) |-> cell_out == CELL_EMPTY)
        else $error("nonzero cell on a non-read result");

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (operation == OP_WRITE || operation == OP_NOP)
        |=> out_valid && op_done == $past(operation))
        else $error("write result not posted next cycle");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (operation == OP_READ || operation == OP_STEP) |=> in_stall)
        else $error("input taken while read or step in progress");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && operation == OP_READ |-> ##2 out_valid && op_done == OP_READ)
        else $error("read result not posted after two cycles");

endmodule

bind falling_sand_grid_step_core fsg_checker u_fsg_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cell_out  (cell_out),
    .op_done   (op_done)
);

`default_nettype wire

/* tb/falling_sand_grid_step_core_tb.sv */
module falling_sand_grid_step_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fsg_pkg::*;

    localparam int GRID_COLS    = 64;
    localparam int GRID_ROWS    = 64;
    localparam int RANDOM_ITEMS = 1500;
    localparam int CYCLE_LIMIT  = 4000000;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE  = 2'd3;
    localparam cell_t                CELL_SPARE = 2'd3;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct {
        cell_t cell_val;
        op_t   op;
    } reply_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [OP_W-1:0]       operation = '0;
    coord_t                x_coord   = '0;
    coord_t                y_coord   = '0;
    cell_t                 cell_in   = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    cell_t                 cell_out;
    logic [OP_W-1:0]       op_done;

    cell_t        grid_cells [0:GRID_ROWS-1][0:GRID_COLS-1];
    cell_t        snap_cells [0:GRID_ROWS-1][0:GRID_COLS-1];
    logic [15:0]  dir_lfsr   = SEED_RESET;
    logic [6:0]   width_reg  = GW_RESET;
    logic [5:0]   height_reg = GH_RESET;

    reply_t       pending_replies [$];
    int           error_count = 0;
    int           cycle_count = 0;
    int           burst_left  = 0;
    bit           pace_sender = 1'b1;
    int           steps_left  = 70;
    int           wide_steps_left = 8;
    logic [15:0]  stall_pattern = '0;
    int           stall_pos = 0;

    falling_sand_grid_step_core #(
        .MAX_COLS(GRID_COLS),
        .MAX_ROWS(GRID_ROWS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .cell_in   (cell_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cell_out  (cell_out),
        .op_done   (op_done)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int cols_in_use();
        if (width_reg < DIM_MIN)
            return DIM_MIN;
        if (width_reg > GW_CAP)
            return GW_CAP;
        return int'(width_reg);
    endfunction

    function automatic int last_row_in_use();
        if (height_reg < DIM_MIN)
            return DIM_MIN;
        if (height_reg > GH_CAP)
            return GH_CAP;
        return int'(height_reg);
    endfunction

    function automatic void set_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GRID_WIDTH:  width_reg = data[6:0];
            CFG_GRID_HEIGHT: height_reg = data[5:0];
            CFG_RNG_SEED:    dir_lfsr = (data == 16'd0) ? 16'd1 : data;
            default: ;
        endcase
    endfunction

    // advance the direction register; true means the diagonal at the lower column is tried first
    function automatic bit lfsr_next_positive();
        logic lsb;
        lsb = dir_lfsr[0];
        dir_lfsr = dir_lfsr >> 1;
        if (lsb)
            dir_lfsr = dir_lfsr ^ LFSR_MASK;
        return dir_lfsr[0];
    endfunction

    function automatic bit cell_free(int c, int r);
        return snap_cells[r][c] == CELL_EMPTY && grid_cells[r][c] == CELL_EMPTY;
    endfunction

    function automatic void settle_sand();
        int w;
        int h;
        int r;
        int c;
        int a;
        int b;
        w = cols_in_use();
        h = last_row_in_use();
        for (r = 0; r < GRID_ROWS; r++)
            for (c = 0; c < GRID_COLS; c++)
            begin
                snap_cells[r][c] = grid_cells[r][c];
                grid_cells[r][c] = CELL_EMPTY;
            end
        for (r = 0; r <= h; r++)
        begin
            grid_cells[r][0] = CELL_WALL;
            grid_cells[r][1] = CELL_WALL;
            grid_cells[r][w-1] = CELL_WALL;
        end
        for (c = 0; c < w; c++)
        begin
            grid_cells[0][c] = CELL_WALL;
            grid_cells[1][c] = CELL_WALL;
            grid_cells[h-1][c] = CELL_WALL;
            grid_cells[h][c] = CELL_WALL;
        end
        for (r = h - 2; r >= 2; r--)
            for (c = 2; c + 1 < w; c++)
            begin
                if (snap_cells[r][c] != CELL_SAND)
                    continue;
                if (lfsr_next_positive())
                begin
                    a = c - 1;
                    b = c + 1;
                end
                else
                begin
                    a = c + 1;
                    b = c - 1;
                end
                if (cell_free(c, r + 1))
                    grid_cells[r+1][c] = CELL_SAND;
                else if (cell_free(a, r + 1))
                    grid_cells[r+1][a] = CELL_SAND;
                else if (cell_free(b, r + 1))
                    grid_cells[r+1][b] = CELL_SAND;
                else
                    grid_cells[r][c] = CELL_SAND;
            end
    endfunction

    function automatic reply_t predict_reply(op_t op, coord_t x, coord_t y, cell_t v);
        reply_t rep;
        bit     in_grid;
        in_grid = (x < cols_in_use()) && (y <= last_row_in_use());
        rep.cell_val = CELL_EMPTY;
        rep.op = op;
        case (op)
            OP_WRITE: if (in_grid) grid_cells[y][x] = v;
            OP_READ:  rep.cell_val = in_grid ? grid_cells[y][x] : grid_cells[0][0];
            OP_STEP:  settle_sand();
            default: ;
        endcase
        return rep;
    endfunction

    task automatic send_word(op_t op, coord_t x, coord_t y, cell_t v);
        int gap;
        if (burst_left == 0)
        begin
            if (pace_sender)
            begin
                gap = $urandom_range(1, 12);
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        in_valid  <= 1'b1;
        operation <= op;
        x_coord   <= x;
        y_coord   <= y;
        cell_in   <= v;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pending_replies.push_back(predict_reply(op, x, y, v));
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        set_register(idx, data);
    endtask

    task automatic test_cell_access();
        send_word(OP_WRITE, 6'd63, 6'd63, CELL_SPARE);
        send_word(OP_READ, 6'd63, 6'd63, CELL_EMPTY);
        send_word(OP_WRITE, 6'd0, 6'd0, CELL_WALL);
        send_word(OP_READ, 6'd0, 6'd0, CELL_EMPTY);
        send_word(OP_NOP, 6'd63, 6'd63, CELL_SPARE);
        wait_idle();
        // upper data bits set, register bits clear: both sizes clamp to the minimum
        write_register(CFG_GRID_WIDTH, 16'hFF80);
        write_register(CFG_GRID_HEIGHT, 16'hFFC0);
        write_register(CFG_RNG_SEED, 16'hFFFF);
        write_register(CFG_SPARE, 16'hFFFF);
        send_word(OP_READ, 6'd63, 6'd63, CELL_EMPTY);
        send_word(OP_WRITE, 6'd5, 6'd0, CELL_SAND);
        send_word(OP_WRITE, 6'd0, 6'd6, CELL_SAND);
        send_word(OP_READ, 6'd4, 6'd5, CELL_EMPTY);
        send_word(OP_READ, 6'd5, 6'd0, CELL_EMPTY);
    endtask

    task automatic test_step_rules();
        wait_idle();
        write_register(CFG_GRID_WIDTH, 16'd8);
        write_register(CFG_GRID_HEIGHT, 16'd8);
        write_register(CFG_RNG_SEED, 16'd0);
        send_word(OP_WRITE, 6'd3, 6'd2, CELL_SAND);
        send_word(OP_WRITE, 6'd5, 6'd3, CELL_SAND);
        send_word(OP_WRITE, 6'd5, 6'd4, CELL_SAND);
        send_word(OP_WRITE, 6'd4, 6'd5, CELL_WALL);
        send_word(OP_WRITE, 6'd6, 6'd6, CELL_SAND);
        send_word(OP_WRITE, 6'd2, 6'd6, CELL_SPARE);
        send_word(OP_WRITE, 6'd2, 6'd5, CELL_SAND);
        send_word(OP_WRITE, 6'd3, 6'd7, CELL_SAND);
        send_word(OP_STEP, 6'd0, 6'd0, CELL_EMPTY);
        send_word(OP_READ, 6'd3, 6'd3, CELL_EMPTY);
        send_word(OP_READ, 6'd5, 6'd5, CELL_EMPTY);
        send_word(OP_READ, 6'd6, 6'd6, CELL_EMPTY);
        send_word(OP_READ, 6'd4, 6'd5, CELL_EMPTY);
        send_word(OP_READ, 6'd2, 6'd5, CELL_EMPTY);
        send_word(OP_READ, 6'd3, 6'd7, CELL_EMPTY);
        wait_idle();
        // grow back: the small step cleared the far corner as well
        write_register(CFG_GRID_WIDTH, 16'h007F);
        write_register(CFG_GRID_HEIGHT, 16'd63);
        send_word(OP_READ, 6'd63, 6'd63, CELL_EMPTY);
    endtask

    task automatic test_random_traffic();
        int          random_items;
        int          phase_no;
        int          n;
        int          k;
        int          pick;
        int          w;
        int          h;
        int          wx0;
        int          wy0;
        int          span_x;
        int          span_y;
        int          steps_in_phase;
        bit          wide_phase;
        logic [15:0] noise;
        logic [6:0]  wv;
        logic [5:0]  hv;
        coord_t      x;
        coord_t      y;
        cell_t       v;
        random_items = 0;
        phase_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            wait_idle();
            wide_phase = (phase_no % 8 == 3) && (wide_steps_left > 0);
            noise = 16'($urandom_range(0, 65535));
            if (wide_phase)
            begin
                pick = $urandom_range(0, 2);
                wv = (pick == 0) ? 7'd64 :
                     (pick == 1) ? 7'($urandom_range(65, 127)) : 7'($urandom_range(40, 63));
                hv = $urandom_range(0, 1) ? 6'd63 : 6'($urandom_range(40, 62));
            end
            else
            begin
                wv = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 4))
                                                 : 7'($urandom_range(5, 20));
                hv = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 4))
                                                 : 6'($urandom_range(5, 20));
            end
            write_register(CFG_GRID_WIDTH, (noise & 16'hFF80) | wv);
            write_register(CFG_GRID_HEIGHT, (noise & 16'hFFC0) | hv);
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 5))
                    0: write_register(CFG_RNG_SEED, 16'h0000);
                    1: write_register(CFG_RNG_SEED, 16'hFFFF);
                    2: write_register(CFG_RNG_SEED, 16'h0001);
                    default: write_register(CFG_RNG_SEED, 16'($urandom_range(0, 65535)));
                endcase
            end
            if ($urandom_range(0, 7) == 0)
                write_register(CFG_SPARE, noise);
            pace_sender = ($urandom_range(0, 3) != 0);
            w = cols_in_use();
            h = last_row_in_use();
            span_x = wide_phase ? 12 : w;
            span_y = wide_phase ? 12 : h + 1;
            wx0 = $urandom_range(0, w - span_x);
            wy0 = $urandom_range(0, h + 1 - span_y);
            steps_in_phase = 0;
            n = $urandom_range(30, 70);
            for (k = 0; k < n && random_items < RANDOM_ITEMS; k++)
            begin
                pick = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < 85)
                begin
                    x = coord_t'(wx0 + $urandom_range(0, span_x - 1));
                    y = coord_t'(wy0 + $urandom_range(0, span_y - 1));
                end
                else
                begin
                    x = coord_t'($urandom_range(0, 63));
                    y = coord_t'($urandom_range(0, 63));
                end
                v = cell_t'($urandom_range(0, 3));
                if (pick < (wide_phase ? 3 : 6) && steps_left > 0 &&
                    (!wide_phase || (steps_in_phase < 2 && wide_steps_left > 0)))
                begin
                    send_word(OP_STEP, x, y, v);
                    steps_left--;
                    steps_in_phase++;
                    if (wide_phase)
                        wide_steps_left--;
                end
                else if (pick < 60)
                begin
                    pick = $urandom_range(0, 99);
                    v = (pick < 65) ? CELL_SAND :
                        (pick < 80) ? CELL_EMPTY :
                        (pick < 92) ? CELL_WALL : CELL_SPARE;
                    send_word(OP_WRITE, x, y, v);
                end
                else if (pick < 94)
                    send_word(OP_READ, x, y, v);
                else
                    send_word(OP_NOP, x, y, v);
                random_items++;
            end
            phase_no++;
        end
    endtask

    always @(negedge clk)
    begin
        if (stall_pos == 0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pattern = 16'h0000;
                1: stall_pattern = 16'($urandom_range(0, 65535));
                2: stall_pattern = 16'($urandom_range(0, 65535) & $urandom_range(0, 65535));
                default: stall_pattern = 16'h0FF0;
            endcase
        end
        out_stall <= stall_pattern[stall_pos];
        stall_pos = (stall_pos + 1) % 16;
    end

    always @(posedge clk)
    begin : check_replies
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("unexpected word: cell_out %0d op_done %0d", cell_out, op_done);
                error_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (cell_out !== want.cell_val)
                begin
                    $error("cell_out: expected %0d, got %0d", want.cell_val, cell_out);
                    error_count++;
                end
                if (op_done !== want.op)
                begin
                    $error("op_done: expected %0d, got %0d", want.op, op_done);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        int r;
        int c;
        for (r = 0; r < GRID_ROWS; r++)
            for (c = 0; c < GRID_COLS; c++)
            begin
                grid_cells[r][c] = CELL_EMPTY;
                snap_cells[r][c] = CELL_EMPTY;
            end
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_cell_access();
        test_step_rules();
        test_random_traffic();
        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
rtl/fsg_pkg.sv
rtl/fsg_ctrl.sv
rtl/fsg_datapath.sv
rtl/falling_sand_grid_step_core.sv
rtl/fsg_checker.sv
tb/falling_sand_grid_step_core_tb.sv
